// File: design/aes256_ctr_offset_stream_defines.svh
// Assertion macros for the AES-256 CTR byte stream checker.
// Used by aesctr_checker.sv; needs clk and rst_n in the including scope.
`ifndef AES256_CTR_OFFSET_STREAM_DEFINES_SVH
`define AES256_CTR_OFFSET_STREAM_DEFINES_SVH

// Same-cycle implication
`define ACS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ACS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/aesctr_pkg.sv
// Shared types, register indexes and AES round functions for the CTR stream.
// No dependencies.
package aesctr_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_KEY0     = 3'd0,
        REG_KEY1     = 3'd1,
        REG_KEY2     = 3'd2,
        REG_KEY3     = 3'd3,
        REG_NONCE_HI = 3'd4,
        REG_NONCE_LO = 3'd5
    } cfg_idx_t;

    // One queued word: data byte plus its block index and lane
    typedef struct packed {
        logic [7:0]  data;
        logic [27:0] blk;
        logic [3:0]  lane;
    } entry_t;

    // Head of the front queue as seen by the back end
    typedef struct packed {
        logic   valid;
        entry_t ent;
    } fifo_head_t;

    localparam logic [2047:0] SBOX_BITS = {
        128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
    };

    function automatic logic [7:0] sbox(input logic [7:0] b);
        logic [7:0] nb;
        nb = ~b;
        return SBOX_BITS[{nb, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] a);
        logic [7:0] a0, a1, a2, a3, all;
        a0  = a[31:24];
        a1  = a[23:16];
        a2  = a[15:8];
        a3  = a[7:0];
        all = a0 ^ a1 ^ a2 ^ a3;
        return {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
                a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
    endfunction

    // One AES round; byte k of the state sits at bits 127-8k down
    function automatic logic [127:0] aes_round(input logic [127:0] s,
                                               input logic [127:0] rk,
                                               input logic last);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[127 - 8 * (i + 4 * c) -: 8] = sbox(s[127 - 8 * (i + 4 * ((c + i) & 3)) -: 8]);
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                t[127 - 32 * c -: 32] = mix_col(t[127 - 32 * c -: 32]);
            end
        end
        return t ^ rk;
    endfunction

    // Next four key schedule words from an eight-word window
    function automatic logic [127:0] key_next4(input logic [255:0] win,
                                               input logic rot,
                                               input logic [7:0] rcon);
        logic [31:0] w7, t, n0, n1, n2, n3;
        w7 = win[31:0];
        t  = rot ? (sub_word({w7[23:0], w7[31:24]}) ^ {rcon, 24'h0}) : sub_word(w7);
        n0 = win[255:224] ^ t;
        n1 = win[223:192] ^ n0;
        n2 = win[191:160] ^ n1;
        n3 = win[159:128] ^ n2;
        return {n0, n1, n2, n3};
    endfunction

endpackage

// File: design/aes256_ctr_offset_stream.sv
// Top level of the AES-256 counter-mode byte stream with loadable position.
// Depends on aesctr_pkg, aesctr_front and aesctr_back.
//
// Usage: bytes go in through a queue-like port (push/full) with run_start and
// start_offset; run_start loads the byte position before the byte is used.
// Results come out through a queue-like port (empty/pop), one per input byte,
// in order. Key and nonce are written through cfg_we/cfg_index/cfg_data; the
// user must write them only while the block is idle, which the block itself
// does not enforce; any write to a listed register drops the cached keystream.
// With the byte's keystream block cached, an accepted byte passes from the input
// queue to the registered output word and empty falls. A new block first runs
// the round-iterative AES-256 engine (start plus fourteen rounds) and is then
// loaded into the cache. Throughput: one byte per cycle within a cached block
// while the receiver keeps up; a byte in a new block waits at the queue head
// until its block is cached. Reset clears the position to 0, empties the queue
// and invalidates the cache; key and nonce reset to zero. When the receiver
// stalls, the output word holds, the four-word input queue fills and full rises.
module aes256_ctr_offset_stream (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        run_start,
    input  logic [31:0] start_offset,
    input  logic        pop,
    output logic        empty,
    output logic [7:0]  result_byte,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import aesctr_pkg::*;

    fifo_head_t head;
    logic       head_pop;

    aesctr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .run_start    (run_start),
        .start_offset (start_offset),
        .head         (head),
        .head_pop     (head_pop)
    );

    aesctr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .head        (head),
        .head_pop    (head_pop),
        .pop         (pop),
        .empty       (empty),
        .result_byte (result_byte)
    );

endmodule

// File: design/aesctr_front.sv
// Front end: tracks the byte position and queues words for the back end.
// Depends on aesctr_pkg.
module aesctr_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [7:0]              data_byte,
    input  logic                    run_start,
    input  logic [31:0]             start_offset,
    output aesctr_pkg::fifo_head_t  head,
    input  logic                    head_pop
);
    import aesctr_pkg::*;

    logic [31:0]        pos_reg, pos_next, pos_cur;
    logic [FIFO_AW:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    entry_t             mem [FIFO_DEPTH];
    logic               wr_en, empty_q;

    assign empty_q = (wr_ptr_reg == rd_ptr_reg);
    assign full    = (wr_ptr_reg[FIFO_AW] != rd_ptr_reg[FIFO_AW]) &&
                     (wr_ptr_reg[FIFO_AW-1:0] == rd_ptr_reg[FIFO_AW-1:0]);
    assign wr_en   = push && !full;

    // Position of the incoming word
    always_comb
    begin
        pos_cur     = run_start ? start_offset : pos_reg;
        pos_next    = wr_en ? pos_cur + 32'd1 : pos_reg;
        wr_ptr_next = wr_ptr_reg + (FIFO_AW + 1)'(wr_en);
        rd_ptr_next = rd_ptr_reg + (FIFO_AW + 1)'(head_pop && !empty_q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg[FIFO_AW-1:0]] <= '{data: data_byte, blk: pos_cur[31:4],
                                              lane: pos_cur[3:0]};
        end
    end

    assign head.valid = !empty_q;
    assign head.ent   = mem[rd_ptr_reg[FIFO_AW-1:0]];

endmodule

// File: design/aesctr_core.sv
// Round-iterative AES-256 encryptor with on-the-fly key expansion.
// Depends on aesctr_pkg.
module aesctr_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         abort,
    input  logic [255:0] key,
    input  logic [127:0] ctr,
    output logic         busy,
    output logic         done,
    output logic [127:0] block
);
    import aesctr_pkg::*;

    logic         busy_reg, busy_next, done_reg, done_next;
    logic [3:0]   rnd_reg, rnd_next;
    logic [7:0]   rcon_reg, rcon_next;
    logic [127:0] st_reg, st_next;
    logic [255:0] win_reg, win_next;
    logic         last_rnd;

    assign last_rnd = (rnd_reg == 4'd14);

    // Round sequencing
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        rnd_next  = rnd_reg;
        rcon_next = rcon_reg;
        st_next   = st_reg;
        win_next  = win_reg;
        if (abort)
        begin
            busy_next = 1'b0;
        end
        else if (start)
        begin
            busy_next = 1'b1;
            rnd_next  = 4'd1;
            rcon_next = 8'h01;
            st_next   = ctr ^ key[255:128];
            win_next  = key;
        end
        else if (busy_reg)
        begin
            st_next  = aes_round(st_reg, win_reg[127:0], last_rnd);
            win_next = {win_reg[127:0], key_next4(win_reg, rnd_reg[0], rcon_reg)};
            rnd_next = rnd_reg + 4'd1;
            if (rnd_reg[0])
            begin
                rcon_next = xtime(rcon_reg);
            end
            if (last_rnd)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
            rcon_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            rnd_reg  <= rnd_next;
            rcon_reg <= rcon_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg  <= st_next;
        win_reg <= win_next;
    end

    assign busy  = busy_reg;
    assign done  = done_reg;
    assign block = st_reg;

endmodule

// File: design/aesctr_back.sv
// Back end: configuration registers, keystream block cache and output word.
// Depends on aesctr_pkg and aesctr_core.
module aesctr_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [2:0]              cfg_index,
    input  logic [63:0]             cfg_data,
    input  aesctr_pkg::fifo_head_t  head,
    output logic                    head_pop,
    input  logic                    pop,
    output logic                    empty,
    output logic [7:0]              result_byte
);
    import aesctr_pkg::*;

    logic [63:0]  key0_reg, key1_reg, key2_reg, key3_reg, nhi_reg, nlo_reg;
    logic [127:0] cache_reg;
    logic [27:0]  cidx_reg, ridx_reg;
    logic         cvalid_reg, cvalid_next, ovalid_reg, ovalid_next;
    logic [7:0]   odata_reg;
    logic         cfg_hit, hit, out_free, eng_start, eng_busy, eng_done;
    logic [127:0] eng_block, ctr;

    // Register write decode
    always_comb
    begin
        case (cfg_index)
            REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3, REG_NONCE_HI, REG_NONCE_LO:
                cfg_hit = cfg_we;
            default:
                cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg <= '0;
            key1_reg <= '0;
            key2_reg <= '0;
            key3_reg <= '0;
            nhi_reg  <= '0;
            nlo_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY0:     key0_reg <= cfg_data;
                REG_KEY1:     key1_reg <= cfg_data;
                REG_KEY2:     key2_reg <= cfg_data;
                REG_KEY3:     key3_reg <= cfg_data;
                REG_NONCE_HI: nhi_reg  <= cfg_data;
                REG_NONCE_LO: nlo_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Hit when the cached block matches the head word's block
    assign hit       = head.valid && cvalid_reg && (cidx_reg == head.ent.blk);
    assign out_free  = !ovalid_reg || pop;
    assign head_pop  = hit && out_free;
    assign eng_start = head.valid && !hit && !eng_busy && !eng_done && !cfg_hit;
    assign ctr       = {nhi_reg, nlo_reg} + {100'd0, head.ent.blk};

    aesctr_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .start (eng_start),
        .abort (cfg_hit),
        .key   ({key0_reg, key1_reg, key2_reg, key3_reg}),
        .ctr   (ctr),
        .busy  (eng_busy),
        .done  (eng_done),
        .block (eng_block)
    );

    always_comb
    begin
        cvalid_next = cvalid_reg;
        if (cfg_hit)
        begin
            cvalid_next = 1'b0;
        end
        else if (eng_done)
        begin
            cvalid_next = 1'b1;
        end
        ovalid_next = head_pop ? 1'b1 : (pop ? 1'b0 : ovalid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cvalid_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            cvalid_reg <= cvalid_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Cache fill and output word
    always_ff @(posedge clk)
    begin
        if (eng_start)
        begin
            ridx_reg <= head.ent.blk;
        end
        if (eng_done)
        begin
            cache_reg <= eng_block;
            cidx_reg  <= ridx_reg;
        end
        if (head_pop)
        begin
            odata_reg <= head.ent.data ^ cache_reg[{~head.ent.lane, 3'b000} +: 8];
        end
    end

    assign empty       = !ovalid_reg;
    assign result_byte = odata_reg;

endmodule

// File: design/aesctr_checker.sv
// Port-level checker for the CTR byte stream, bound to the top level.
// Depends on aes256_ctr_offset_stream_defines.svh.
`include "aes256_ctr_offset_stream_defines.svh"

module aesctr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic       pop,
    input logic       empty,
    input logic [7:0] result_byte
);
    logic [3:0] cnt_reg;

    // Words accepted but not yet taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_reg + 4'(push && !full) - 4'(pop && !empty);
        end
    end

    `ACS_ASSERT_NXT(a_result_held, !empty && !pop, !empty, "waiting result vanished")
    `ACS_ASSERT_NXT(a_result_stable, !empty && !pop, $stable(result_byte), "held result changed")
    `ACS_ASSERT_IMP(a_no_spurious, !empty, cnt_reg != 4'd0, "result without input word")
    `ACS_ASSERT_IMP(a_idle_not_full, cnt_reg == 4'd0, !full, "full while nothing in flight")

endmodule

bind aes256_ctr_offset_stream aesctr_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .pop         (pop),
    .empty       (empty),
    .result_byte (result_byte)
);
